// File: rtl/pcdc_pkg.sv
// Package for the pixel color depth classifier.
// Holds the format codes, the pixel test flags and the expansion lookup masks.
// No dependencies.
`default_nettype none

package pcdc_pkg;

  typedef enum logic [1:0] {
    FMT_555 = 2'd0,
    FMT_565 = 2'd1,
    FMT_888 = 2'd2
  } fmt_t;

  // Per-pixel test results.
  typedef struct packed {
    logic fits_555;
    logic fits_565;
  } pix_flags_t;

  localparam int unsigned ChanWidth = 8;
  localparam int unsigned ChanCodes = 1 << ChanWidth;

  // Bit v is set when v = ceil((i*510/31)/2) for some i in 0..31.
  function automatic logic [ChanCodes-1:0] build_exp5_mask();
    logic [ChanCodes-1:0] m;
    int unsigned          x;
    m = '0;
    for (int unsigned i = 0; i <= 31; i++) begin
      x = (i * 510) / 31;
      m[ChanWidth'((x + (x & 1)) >> 1)] = 1'b1;
    end
    return m;
  endfunction

  // Same for the 6-bit codes, i in 0..63.
  function automatic logic [ChanCodes-1:0] build_exp6_mask();
    logic [ChanCodes-1:0] m;
    int unsigned          x;
    m = '0;
    for (int unsigned i = 0; i <= 63; i++) begin
      x = (i * 510) / 63;
      m[ChanWidth'((x + (x & 1)) >> 1)] = 1'b1;
    end
    return m;
  endfunction

  localparam logic [ChanCodes-1:0] EXP5_MASK = build_exp5_mask();
  localparam logic [ChanCodes-1:0] EXP6_MASK = build_exp6_mask();

endpackage

`default_nettype wire

// File: rtl/pcdc_pixel_check.sv
// Per-pixel membership tests against the 5-bit and 6-bit expansion sets.
// Depends on pcdc_pkg (masks, pix_flags_t).
`default_nettype none

module pcdc_pixel_check (
  input  wire logic [7:0]             red,
  input  wire logic [7:0]             green,
  input  wire logic [7:0]             blue,
  input  wire logic [7:0]             alpha,
  output pcdc_pkg::pix_flags_t        flags
);

  logic rb_ok;
  logic transparent;

  assign rb_ok       = pcdc_pkg::EXP5_MASK[red] & pcdc_pkg::EXP5_MASK[blue];
  assign transparent = (alpha == 8'd0);

  // Transparent pixels never disqualify a row.
  assign flags.fits_555 = transparent | (rb_ok & pcdc_pkg::EXP5_MASK[green]);
  assign flags.fits_565 = transparent | (rb_ok & pcdc_pkg::EXP6_MASK[green]);

endmodule

`default_nettype wire

// File: rtl/pixel_color_depth_classifier.sv
// Pixel color depth classifier, top level. Uses pcdc_pkg and pcdc_pixel_check.
// A pixel is registered in the input stage, then tested and folded into the row/image
// state; the format code is loaded into the output register when the image-end pixel
// leaves the input stage. Throughput: one pixel per cycle, set by the
// single input stage; it stalls only when an image-end pixel meets a full output.
// Reset (rst_n low, synchronous): stages empty, row flags 1, format 555.
`default_nettype none

module pixel_color_depth_classifier (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_red,
  input  wire logic [7:0] in_green,
  input  wire logic [7:0] in_blue,
  input  wire logic [7:0] in_alpha,
  input  wire logic       in_row_end,
  input  wire logic       in_image_end,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_format_code
);

  // Input stage
  logic       s1_valid_r;
  logic [7:0] s1_red_r, s1_green_r, s1_blue_r, s1_alpha_r;
  logic       s1_row_end_r, s1_image_end_r;
  logic       s1_adv;

  // Classification state
  logic             row555_r, row555_nxt;
  logic             row565_r, row565_nxt;
  pcdc_pkg::fmt_t   fmt_r, fmt_nxt, fmt_closed;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  pcdc_pkg::fmt_t   out_fmt_r;

  pcdc_pkg::pix_flags_t pix_flags;
  logic                 f555, f565;

  // Only an image-end transaction needs room in the output register.
  assign s1_adv   = s1_valid_r & ~(s1_image_end_r & out_valid_r & ~out_ready);
  assign in_ready = ~s1_valid_r | s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_red_r       <= in_red;
      s1_green_r     <= in_green;
      s1_blue_r      <= in_blue;
      s1_alpha_r     <= in_alpha;
      s1_row_end_r   <= in_row_end;
      s1_image_end_r <= in_image_end;
    end
  end

  pcdc_pixel_check u_check (
    .red   (s1_red_r),
    .green (s1_green_r),
    .blue  (s1_blue_r),
    .alpha (s1_alpha_r),
    .flags (pix_flags)
  );

  assign f555 = row555_r & pix_flags.fits_555;
  assign f565 = row565_r & pix_flags.fits_565;

  // Row-close decision; 888 is sticky until image end.
  always_comb begin
    fmt_closed = fmt_r;
    if (fmt_r != pcdc_pkg::FMT_888) begin
      if (!f555 && !f565) begin
        fmt_closed = pcdc_pkg::FMT_888;
      end else if (!f555 && fmt_r == pcdc_pkg::FMT_555) begin
        fmt_closed = pcdc_pkg::FMT_565;
      end
    end
  end

  always_comb begin
    row555_nxt    = row555_r;
    row565_nxt    = row565_r;
    fmt_nxt       = fmt_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    if (s1_adv) begin
      row555_nxt = f555;
      row565_nxt = f565;
      if (s1_row_end_r || s1_image_end_r) begin
        row555_nxt = 1'b1;
        row565_nxt = 1'b1;
        fmt_nxt    = fmt_closed;
      end
      if (s1_image_end_r) begin
        fmt_nxt       = pcdc_pkg::FMT_555;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row555_r    <= 1'b1;
      row565_r    <= 1'b1;
      fmt_r       <= pcdc_pkg::FMT_555;
      out_valid_r <= 1'b0;
    end else begin
      row555_r    <= row555_nxt;
      row565_r    <= row565_nxt;
      fmt_r       <= fmt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_image_end_r) begin
      out_fmt_r <= fmt_closed;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_format_code = out_fmt_r;

  // An image-end transaction must wait while the output is stalled.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_image_end_r && out_valid_r && !out_ready) |=> s1_valid_r)
    else $error("image-end pixel dropped while output stalled");

  // State returns to its reset values after each image.
  a_image_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_image_end_r) |=>
      (fmt_r == pcdc_pkg::FMT_555 && row555_r && row565_r))
    else $error("state not restarted after image end");

  // 888 holds until the image closes.
  a_888_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (fmt_r == pcdc_pkg::FMT_888 && !(s1_adv && s1_image_end_r)) |=>
      (fmt_r == pcdc_pkg::FMT_888))
    else $error("888 format left before image end");

endmodule

`default_nettype wire

// File: bench/pixel_color_depth_classifier_tb.sv
// Testbench for pixel_color_depth_classifier: directed and random pixel streams,
// each format code checked against a local predictor. Depends on pcdc_pkg and the RTL.
`timescale 1ns / 1ps

module pixel_color_depth_classifier_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 10;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_red = '0;
  logic [7:0] in_green = '0;
  logic [7:0] in_blue = '0;
  logic [7:0] in_alpha = '0;
  logic       in_row_end = 1'b0;
  logic       in_image_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_format_code;

  pixel_color_depth_classifier dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_alpha        (in_alpha),
    .in_row_end      (in_row_end),
    .in_image_end    (in_image_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_format_code (out_format_code)
  );

  always #5 clk = ~clk;

  // predictor state
  bit   is_code5 [0:255];
  bit   is_code6 [0:255];
  bit   row_ok_555 = 1'b1;
  bit   row_ok_565 = 1'b1;
  pcdc_pkg::fmt_t predicted_format = pcdc_pkg::FMT_555;
  pcdc_pkg::fmt_t expected_formats [$];

  int   mismatches = 0;
  int   cycle_count = 0;
  int   pixels_sent = 0;
  int   in_idle_pct = 11;
  int   out_idle_pct = 54;
  bit   hold_request = 1'b0;
  int   hold_left = 0;

  function automatic logic [7:0] expand(input int unsigned code, input int unsigned max_code);
    int unsigned x;
    x = (code * 510) / max_code;
    return 8'((x + (x & 1)) >> 1);
  endfunction

  task automatic build_code_tables();
    for (int v = 0; v < 256; v++) begin
      is_code5[v] = 1'b0;
      is_code6[v] = 1'b0;
    end
    for (int unsigned i = 0; i <= 31; i++) is_code5[expand(i, 31)] = 1'b1;
    for (int unsigned i = 0; i <= 63; i++) is_code6[expand(i, 63)] = 1'b1;
  endtask

  task automatic predict_format(input logic [7:0] r, g, b, a, input logic re, ie);
    bit rb;
    if (a != 8'd0) begin
      rb = is_code5[r] && is_code5[b];
      row_ok_555 &= rb & is_code5[g];
      row_ok_565 &= rb & is_code6[g];
    end
    // image end also closes the open row
    if (re || ie) begin
      if (predicted_format != pcdc_pkg::FMT_888) begin
        if (!row_ok_555 && predicted_format == pcdc_pkg::FMT_555)
          predicted_format = pcdc_pkg::FMT_565;
        if (!row_ok_555 && !row_ok_565) predicted_format = pcdc_pkg::FMT_888;
      end
      row_ok_555 = 1'b1;
      row_ok_565 = 1'b1;
    end
    if (ie) begin
      expected_formats.push_back(predicted_format);
      predicted_format = pcdc_pkg::FMT_555;
    end
  endtask

  task automatic send_pixel(input logic [7:0] r, g, b, a, input logic re, ie);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_red       <= r;
    in_green     <= g;
    in_blue      <= b;
    in_alpha     <= a;
    in_row_end   <= re;
    in_image_end <= ie;
    do @(posedge clk); while (!in_ready);
    predict_format(r, g, b, a, re, ie);
    pixels_sent++;
  endtask

  // kind 0: 5-bit code, 1: 6-bit code, otherwise any value
  function automatic logic [7:0] pick_channel(input int kind);
    case (kind)
      0: return expand($urandom_range(31), 31);
      1: return expand($urandom_range(63), 63);
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic send_image(input int rows, input int max_width);
    int   width;
    int   row_kind;
    int   rb_kind;
    int   g_kind;
    logic last;
    for (int row = 0; row < rows; row++) begin
      width = $urandom_range(1, max_width);
      row_kind = $urandom_range(5);
      for (int col = 0; col < width; col++) begin
        rb_kind = 0;
        g_kind = (row_kind >= 2) ? 1 : 0;
        // dirty rows: occasional stray channels
        if (row_kind == 5 && $urandom_range(2) == 0) rb_kind = 2;
        if (row_kind >= 4 && $urandom_range(2) == 0) g_kind = 2;
        last = (row == rows - 1) && (col == width - 1);
        send_pixel(pick_channel(rb_kind), pick_channel(g_kind), pick_channel(rb_kind),
                   pick_alpha(), (col == width - 1) && !(last && $urandom_range(3) == 0),
                   last);
      end
    end
  endtask

  task automatic send_noise(input int count);
    for (int k = 0; k < count; k++)
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 $urandom_range(3) == 0, $urandom_range(9) == 0);
  endtask

  // receiver: random idling plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    pcdc_pkg::fmt_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_formats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: format_code %0d", out_format_code);
      end else begin
        want = expected_formats.pop_front();
        if (out_format_code !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("format_code mismatch: expected %0d got %0d", want, out_format_code);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic test_single_pixel_formats();
    send_pixel(8'd0, 8'd0, 8'd0, 8'd255, 1'b1, 1'b1);          // 555
    send_pixel(8'd255, 8'd255, 8'd255, 8'd1, 1'b1, 1'b1);      // 555 at top code
    send_pixel(8'd0, expand(1, 63), 8'd0, 8'd255, 1'b1, 1'b1); // green 6-bit only: 565
    send_pixel(8'd1, 8'd0, 8'd0, 8'd255, 1'b1, 1'b1);          // bad red: 888
    send_pixel(8'd0, 8'd0, 8'd254, 8'd128, 1'b1, 1'b1);        // bad blue: 888
  endtask

  task automatic test_transparent_pixels();
    send_pixel(8'd1, 8'd3, 8'd254, 8'd0, 1'b0, 1'b0);
    send_pixel(8'd255, 8'd1, 8'd7, 8'd0, 1'b1, 1'b0);          // transparent-only row
    send_pixel(8'd8, 8'd8, 8'd8, 8'd255, 1'b0, 1'b0);
    send_pixel(8'd77, 8'd77, 8'd77, 8'd0, 1'b1, 1'b1);         // 555
  endtask

  task automatic test_image_end_closes_row();
    send_pixel(8'd0, 8'd0, 8'd0, 8'd255, 1'b1, 1'b0);
    send_pixel(8'd9, 8'd9, 8'd9, 8'd255, 1'b0, 1'b1);          // 888 without row end
    send_pixel(8'd0, expand(3, 63), 8'd0, 8'd255, 1'b0, 1'b1); // 565 without row end
  endtask

  task automatic test_format_transitions();
    // 888 holds over a clean row
    send_pixel(8'd2, 8'd0, 8'd0, 8'd255, 1'b1, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd255, 1'b1, 1'b1);
    // 565 stays through a 555 row and another 565 row
    send_pixel(8'd0, expand(1, 63), 8'd0, 8'd255, 1'b1, 1'b0);
    send_pixel(8'd16, 8'd16, 8'd16, 8'd255, 1'b1, 1'b0);
    send_pixel(8'd255, expand(5, 63), 8'd0, 8'd255, 1'b1, 1'b1);
    // 565 then a row failing both tests goes to 888
    send_pixel(8'd0, expand(1, 63), 8'd0, 8'd255, 1'b1, 1'b0);
    send_pixel(8'd0, 8'd1, 8'd0, 8'd255, 1'b1, 1'b1);
    // 555 row, 565 row, 555 row: 565
    send_pixel(8'd0, 8'd0, 8'd0, 8'd255, 1'b1, 1'b0);
    send_pixel(8'd0, expand(7, 63), 8'd0, 8'd255, 1'b1, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd255, 1'b1, 1'b1);
  endtask

  task automatic test_random_images(input int quota);
    int start;
    start = pixels_sent;
    while (pixels_sent - start < quota) begin
      if ($urandom_range(9) == 0) send_noise($urandom_range(1, 8));
      else send_image($urandom_range(1, 4), 6);
    end
  endtask

  task automatic test_output_backpressure();
    hold_request = 1'b1;
    // single-pixel images pile up behind the stalled output
    for (int k = 0; k < 40; k++)
      send_pixel(pick_channel($urandom_range(2)), pick_channel($urandom_range(2)),
                 pick_channel($urandom_range(2)), pick_alpha(), $urandom_range(1), 1'b1);
  endtask

  initial begin
    build_code_tables();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    in_idle_pct = 11;
    out_idle_pct = 54;
    test_single_pixel_formats();
    test_transparent_pixels();
    test_image_end_closes_row();
    test_format_transitions();
    test_random_images(420);

    in_idle_pct = 54;
    out_idle_pct = 11;
    test_random_images(420);
    test_output_backpressure();

    in_idle_pct = 0;
    out_idle_pct = 0;
    test_random_images(410);

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_formats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_formats.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
